[hw/rtl/sss_pkg.sv]
// Shared types, constants and register indexes of the stream substring search block.
`default_nettype none

package sss_pkg;

  // Default sizes of the search window and of the byte position counter
  localparam int unsigned MAX_PATTERN_DEF = 32;
  localparam int unsigned OFFSET_BITS_DEF = 32;

  // Needle storage: four 64-bit words, 32 bytes, byte i at bits 8*i
  localparam int unsigned NEEDLE_BYTES  = 32;
  localparam int unsigned NEEDLE_IDX_W  = $clog2(NEEDLE_BYTES);
  localparam int unsigned WORD_COUNT    = 4;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned RES_OFFSET_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_WORD0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_WORD1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_WORD2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_WORD3  = 3'd4;

  typedef logic [NEEDLE_BYTES-1:0][7:0] needle_t;
  typedef logic [WORD_COUNT-1:0][CFG_DATA_W-1:0] needle_words_t;

  // One haystack byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } req_t;

  // One search result
  typedef struct packed {
    logic                    found;
    logic [RES_OFFSET_W-1:0] match_offset;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/sss_cell.sv]
// One window cell: holds a haystack byte, compares it with its needle byte, passes it on.
`default_nettype none

module sss_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             advance_i,
  input  wire logic [7:0]       byte_i,
  input  wire sss_pkg::needle_t needle_i,
  input  wire logic [sss_pkg::LEN_W-1:0] length_i,
  input  wire logic             match_i,
  output logic                  match_o,
  output logic [7:0]            byte_o
);
  import sss_pkg::*;

  logic [LEN_W-1:0]        sel;
  logic                    in_use;
  logic [7:0]              needle_byte;
  logic [7:0]              byte_q;

  // Window position CELL_IDX lines up with needle byte length-1-CELL_IDX
  assign sel         = length_i - LEN_W'(CELL_IDX + 1);
  assign in_use      = length_i > LEN_W'(CELL_IDX);
  assign needle_byte = needle_i[sel[NEEDLE_IDX_W-1:0]];

  // Fold this cell's compare into the running match from the far end
  assign match_o = match_i & (~in_use | (byte_i == needle_byte));

  // Hold the byte for the next position down the row
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

[hw/rtl/stream_substring_search_core.sv]
// Top level: streaming first-match substring search over a row of window cells.
// Latency: the result appears in the cycle after the request carrying last_byte is taken.
// Throughput: one haystack byte per cycle while results are taken; all window compares run
// in parallel in the cell row. A waiting result holds off every request until it is taken.
// Reset: needle, position counter and match state clear asynchronously; the window bytes
// are not reset, as only bytes of the current haystack are ever compared.
`default_nettype none

module stream_substring_search_core #(
  parameter int unsigned MAX_PATTERN = sss_pkg::MAX_PATTERN_DEF,
  parameter int unsigned OFFSET_BITS = sss_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [sss_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                             req_valid_i,
  output logic                                  req_ready_o,
  input  wire sss_pkg::req_t                    req_i,
  output logic                                  res_valid_o,
  input  wire logic                             res_ready_i,
  output sss_pkg::res_t                         res_o
);
  import sss_pkg::*;

  logic [LEN_W-1:0]          len_q;
  needle_words_t             words_q;
  needle_t                   needle;

  logic [OFFSET_BITS-1:0]    pos_q, pos_d;
  logic                      seen_q, seen_d;
  logic [OFFSET_BITS-1:0]    first_q, first_d;
  logic                      res_valid_q;
  res_t                      res_q, res_d;

  logic                      accept;
  logic [LEN_W-1:0]          len_m1;
  logic                      len_ok;
  logic                      pos_ok;
  logic                      hit;
  logic [OFFSET_BITS-1:0]    offset_now;

  logic [MAX_PATTERN:0]          chain;
  logic [MAX_PATTERN-1:0][7:0]   win;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      words_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NEEDLE_LENGTH: len_q      <= cfg_wdata_i[LEN_W-1:0];
        REG_NEEDLE_WORD0:  words_q[0] <= cfg_wdata_i;
        REG_NEEDLE_WORD1:  words_q[1] <= cfg_wdata_i;
        REG_NEEDLE_WORD2:  words_q[2] <= cfg_wdata_i;
        REG_NEEDLE_WORD3:  words_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign needle = needle_t'(words_q);

  // Row of cells; the current byte enters at position zero
  assign accept       = req_valid_i & req_ready_o;
  assign win[0]       = req_i.data_byte;
  assign chain[MAX_PATTERN] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k < MAX_PATTERN - 1) begin : g_mid
      sss_cell #(
        .CELL_IDX (k)
      ) u_cell (
        .clk_i     (clk_i),
        .advance_i (accept),
        .byte_i    (win[k]),
        .needle_i  (needle),
        .length_i  (len_q),
        .match_i   (chain[k+1]),
        .match_o   (chain[k]),
        .byte_o    (win[k+1])
      );
    end else begin : g_end
      sss_cell #(
        .CELL_IDX (k)
      ) u_cell (
        .clk_i     (clk_i),
        .advance_i (accept),
        .byte_i    (win[k]),
        .needle_i  (needle),
        .length_i  (len_q),
        .match_i   (chain[k+1]),
        .match_o   (chain[k]),
        .byte_o    ()
      );
    end
  end

  // Qualify the window match: usable length, enough bytes seen, nothing latched yet
  assign len_m1     = len_q - LEN_W'(1);
  assign len_ok     = (len_q != '0) && (len_q <= LEN_W'(MAX_PATTERN));
  assign pos_ok     = pos_q >= OFFSET_BITS'(len_m1);
  assign hit        = len_ok & pos_ok & ~seen_q & chain[0];
  assign offset_now = pos_q - OFFSET_BITS'(len_m1);

  // Next stream state and result
  always_comb begin
    seen_d  = seen_q | hit;
    first_d = hit ? offset_now : first_q;
    pos_d   = (pos_q != '1) ? pos_q + OFFSET_BITS'(1) : pos_q;
    res_d.found        = seen_d;
    res_d.match_offset = seen_d ? RES_OFFSET_W'(first_d) : '0;
  end

  // Advance the stream state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      seen_q  <= 1'b0;
      first_q <= '0;
    end else if (accept) begin
      if (req_i.last_byte) begin
        pos_q   <= '0;
        seen_q  <= 1'b0;
        first_q <= '0;
      end else begin
        pos_q   <= pos_d;
        seen_q  <= seen_d;
        first_q <= first_d;
      end
    end
  end

  // Output register; drop valid once the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept && req_i.last_byte) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.last_byte) begin
      res_q <= res_d;
    end
  end

  assign req_ready_o = ~res_valid_q | res_ready_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
